@@ rtl/core/angle_bias_kalman_filter_macros.svh @@
// Assertion macros shared by the checker of the angle and bias Kalman filter.
// Include by bare file name; no other dependencies.
`ifndef ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABKF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABKF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/abkf_pkg.sv @@
// Package of the angle and bias Kalman filter: register indexes, reset values,
// the divider status type and the saturation helper. No dependencies.
`default_nettype none

package abkf_pkg;

  localparam logic [1:0] CFG_Q_ANGLE   = 2'd0;
  localparam logic [1:0] CFG_Q_BIAS    = 2'd1;
  localparam logic [1:0] CFG_R_MEASURE = 2'd2;

  localparam logic [15:0] Q_ANGLE_RESET   = 16'd66;
  localparam logic [15:0] Q_BIAS_RESET    = 16'd197;
  localparam logic [15:0] R_MEASURE_RESET = 16'd1966;

  localparam logic signed [52:0] SAT_HI = 53'sd2147483647;
  localparam logic signed [52:0] SAT_LO = -53'sd2147483648;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [52:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/abkf_mac.sv @@
// Shared multiply, round and accumulate unit of the angle and bias Kalman filter.
// Depends on abkf_pkg for the saturation helper.
`default_nettype none

module abkf_mac (
  input  logic               clk,
  input  logic               load,
  input  logic signed [33:0] op_a,
  input  logic signed [32:0] op_b,
  input  logic signed [31:0] base,
  input  logic               sub,
  output logic signed [31:0] result
);
  import abkf_pkg::*;

  logic signed [66:0] prod;
  logic signed [31:0] base_q;
  logic               sub_q;
  logic signed [66:0] biased;
  logic signed [50:0] rounded;
  logic signed [52:0] acc;

  always_ff @(posedge clk) begin
    if (load) begin
      prod   <= op_a * op_b;
      base_q <= base;
      sub_q  <= sub;
    end
  end

  // Round half up: add one half, then drop the 16 extra fraction bits.
  assign biased  = prod + 67'sd32768;
  assign rounded = biased[66:16];
  assign acc     = 53'(base_q) + (sub_q ? -53'(rounded) : 53'(rounded));
  assign result  = sat32(acc);

endmodule

`default_nettype wire

@@ rtl/core/abkf_div.sv @@
// Iterative signed divider for the Kalman gains: (num * 2^16) / den, truncated
// toward zero, saturated to 32 bits, zero when den is zero. Depends on abkf_pkg.
`default_nettype none

module abkf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [31:0]        num,
  input  logic signed [32:0]        den,
  output abkf_pkg::div_status_t     status,
  output logic signed [31:0]        quotient
);
  import abkf_pkg::*;

  localparam int DvdW = 48;
  localparam logic [5:0] LAST_STEP = 6'(DvdW - 1);

  logic [DvdW-1:0] dvd;
  logic [33:0]     rem;
  logic [32:0]     dmag;
  logic [5:0]      cnt;
  logic            neg;
  logic            zero;
  logic [31:0]     num_mag;
  logic [33:0]     rem_sh;
  logic            ge;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh  = {rem[32:0], dvd[DvdW-1]};
  assign ge      = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start && !status.busy) begin
        status.busy <= 1'b1;
        cnt         <= '0;
      end else if (status.busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == LAST_STEP) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // Restoring division: quotient bits shift into the dividend register.
  always_ff @(posedge clk) begin
    if (start && !status.busy) begin
      dvd  <= {num_mag, 16'b0};
      rem  <= '0;
      dmag <= den[32] ? 33'(-den) : 33'(den);
      neg  <= num[31] ^ den[32];
      zero <= (den == '0);
    end else if (status.busy) begin
      rem <= ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
      dvd <= {dvd[DvdW-2:0], ge};
    end
  end

  always_comb begin
    if (zero) begin
      quotient = '0;
    end else if (neg) begin
      quotient = (dvd > 48'd2147483648) ? 32'sh80000000 : 32'(-dvd[31:0]);
    end else begin
      quotient = (dvd > 48'd2147483647) ? 32'sh7fffffff : dvd[31:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/angle_bias_kalman_filter.sv @@
// Angle and gyro bias Kalman filter. One sample at a time: between the sample
// transfer and result_valid it makes eleven passes through the shared
// multiply-accumulate unit, two divider runs of 48 steps each, and one step each
// to form the innovation and to load the output. A waiting result holds the next
// sample off. Synchronous reset restores register defaults and clears state.
`default_nettype none

module angle_bias_kalman_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  input  logic [15:0]        time_step,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] angle_estimate,
  output logic signed [31:0] bias_estimate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import abkf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_CORR = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [3:0] OP_ANGLE_PRED = 4'd0;
  localparam logic [3:0] OP_P00        = 4'd1;
  localparam logic [3:0] OP_P01        = 4'd2;
  localparam logic [3:0] OP_P10        = 4'd3;
  localparam logic [3:0] OP_P11        = 4'd4;
  localparam logic [3:0] OP_ANGLE_CORR = 4'd5;
  localparam logic [3:0] OP_BIAS       = 4'd6;
  localparam logic [3:0] OP_C0         = 4'd7;
  localparam logic [3:0] OP_C1         = 4'd8;
  localparam logic [3:0] OP_C2         = 4'd9;
  localparam logic [3:0] OP_C3         = 4'd10;

  logic [2:0]  state;
  logic [3:0]  op;
  logic        div_sel;
  logic [15:0] q_angle, q_bias, r_measure;

  logic signed [31:0] angle, bias, c0, c1, c2, c3;
  logic signed [31:0] p00, p01, p10, p11, k0, k1, y, z, rate;
  logic signed [32:0] s;
  logic [15:0]        dt;

  logic signed [33:0] mac_a;
  logic signed [32:0] mac_b;
  logic signed [31:0] mac_base;
  logic               mac_sub;
  logic signed [31:0] mac_res;
  logic signed [32:0] dt_s;

  div_status_t        div_stat;
  logic signed [31:0] div_q;
  logic               div_start;

  assign sample_ready = (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign dt_s         = $signed({17'b0, dt});
  assign div_start    = (state == S_DIVS) && !div_stat.busy;

  always_comb begin
    mac_a    = '0;
    mac_b    = dt_s;
    mac_base = '0;
    mac_sub  = 1'b0;
    case (op)
      OP_ANGLE_PRED: begin
        mac_a    = 34'(33'(rate) - 33'(bias));
        mac_base = angle;
      end
      OP_P00: begin
        mac_a    = $signed({18'b0, q_angle}) - 34'(c2) - 34'(c1);
        mac_base = c0;
      end
      OP_P01: begin
        mac_a    = 34'(c3);
        mac_base = c1;
        mac_sub  = 1'b1;
      end
      OP_P10: begin
        mac_a    = 34'(c3);
        mac_base = c2;
        mac_sub  = 1'b1;
      end
      OP_P11: begin
        mac_a    = $signed({18'b0, q_bias});
        mac_base = c3;
      end
      OP_ANGLE_CORR: begin
        mac_a    = 34'(k0);
        mac_b    = 33'(y);
        mac_base = angle;
      end
      OP_BIAS: begin
        mac_a    = 34'(k1);
        mac_b    = 33'(y);
        mac_base = bias;
      end
      OP_C0: begin
        mac_a    = 34'(k0);
        mac_b    = 33'(p00);
        mac_base = p00;
        mac_sub  = 1'b1;
      end
      OP_C1: begin
        mac_a    = 34'(k0);
        mac_b    = 33'(p01);
        mac_base = p01;
        mac_sub  = 1'b1;
      end
      OP_C2: begin
        mac_a    = 34'(k1);
        mac_b    = 33'(p00);
        mac_base = p10;
        mac_sub  = 1'b1;
      end
      OP_C3: begin
        mac_a    = 34'(k1);
        mac_b    = 33'(p01);
        mac_base = p11;
        mac_sub  = 1'b1;
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  abkf_mac u_mac (
    .clk    (clk),
    .load   (state == S_MUL0),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .base   (mac_base),
    .sub    (mac_sub),
    .result (mac_res)
  );

  abkf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_sel ? p10 : p00),
    .den      (s),
    .status   (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_ANGLE_PRED;
      div_sel      <= 1'b0;
      result_valid <= 1'b0;
      q_angle      <= Q_ANGLE_RESET;
      q_bias       <= Q_BIAS_RESET;
      r_measure    <= R_MEASURE_RESET;
      angle        <= '0;
      bias         <= '0;
      c0           <= '0;
      c1           <= '0;
      c2           <= '0;
      c3           <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_Q_ANGLE:   q_angle   <= cfg_data;
          CFG_Q_BIAS:    q_bias    <= cfg_data;
          CFG_R_MEASURE: r_measure <= cfg_data;
          default:       ;
        endcase
      end

      if (state == S_DONE && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_MUL0;
            op    <= OP_ANGLE_PRED;
          end
        end
        S_MUL0: begin
          state <= S_MUL1;
        end
        S_MUL1: begin
          case (op)
            OP_ANGLE_PRED: angle <= mac_res;
            OP_P00:        p00   <= mac_res;
            OP_P01:        p01   <= mac_res;
            OP_P10:        p10   <= mac_res;
            OP_P11:        p11   <= mac_res;
            OP_ANGLE_CORR: angle <= mac_res;
            OP_BIAS:       bias  <= mac_res;
            OP_C0:         c0    <= mac_res;
            OP_C1:         c1    <= mac_res;
            OP_C2:         c2    <= mac_res;
            OP_C3:         c3    <= mac_res;
            default:       ;
          endcase
          op <= op + 4'd1;
          if (op == OP_P11) begin
            state <= S_CORR;
          end else if (op == OP_C3) begin
            state <= S_DONE;
          end else begin
            state <= S_MUL0;
          end
        end
        S_CORR: begin
          y       <= sat32(53'(z) - 53'(angle));
          s       <= 33'(p00) + $signed({17'b0, r_measure});
          div_sel <= 1'b0;
          state   <= S_DIVS;
        end
        S_DIVS: begin
          if (div_start) begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_stat.done) begin
            if (!div_sel) begin
              k0      <= div_q;
              div_sel <= 1'b1;
              state   <= S_DIVS;
            end else begin
              k1    <= div_q;
              op    <= OP_ANGLE_CORR;
              state <= S_MUL0;
            end
          end
        end
        S_DONE: begin
          // The finished result waits here until the output register is free.
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      z    <= measured_angle;
      rate <= measured_rate;
      dt   <= time_step;
    end
    if (state == S_DONE && (!result_valid || result_ready)) begin
      angle_estimate <= angle;
      bias_estimate  <= bias;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/abkf_checker.sv @@
// Port-level checker of the angle and bias Kalman filter, bound to the top level.
// Depends on angle_bias_kalman_filter_macros.svh.
`default_nettype none

`include "angle_bias_kalman_filter_macros.svh"

module abkf_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_ready,
  input logic result_valid,
  input logic result_ready
);

  // The block works on one sample at a time and is busy right after a transfer.
  `ABKF_ASSERT_NEXT(a_busy_after_take, clk, rst, sample_valid && sample_ready, !sample_ready, "sample_ready high right after a sample transfer")

  // An idle block stays idle until a sample arrives.
  `ABKF_ASSERT_NEXT(a_idle_holds, clk, rst, sample_ready && !sample_valid, sample_ready, "sample_ready dropped with no sample transfer")

  // A new result appears only as the block returns to idle.
  `ABKF_ASSERT_NOW(a_result_at_idle, clk, rst, $rose(result_valid), sample_ready, "result appeared while the block was busy")

  // A waiting result is not withdrawn.
  `ABKF_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, result_valid, "result_valid dropped before its transfer")

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (.*);

`default_nettype wire
